FILE: rtl/lpm_pkg.sv
`timescale 1ns / 1ps

package lpm_pkg;

    localparam int KEY_BITS = 32;
    localparam int LEN_BITS = 6;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_LEN   = 2'd3;

    localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(KEY_BITS);

    // Request held steady for the whole scan of the chain.
    typedef struct packed {
        logic [1:0]          func;
        logic [LEN_BITS-1:0] len;
        logic [KEY_BITS-1:0] addr;
        logic [KEY_BITS-1:0] key;
    } lpm_op_t;

    // Running result handed from cell to cell.
    typedef struct packed {
        logic [LEN_BITS-1:0] best_len;
        logic                exact_found;
        logic                free_found;
    } lpm_carry_t;

    // Table update applied in the commit cycle.
    typedef struct packed {
        logic upd;
        logic ins;
        logic del;
    } lpm_commit_t;

    function automatic logic [KEY_BITS-1:0] len_mask(input logic [LEN_BITS-1:0] len);
        logic [LEN_BITS-1:0] shift;
        shift = MAX_LEN - len;
        if (len == '0)
            return '0;
        else
            return {KEY_BITS{1'b1}} << shift;
    endfunction

endpackage

FILE: rtl/ipv4_longest_prefix_match_table.sv
`timescale 1ns / 1ps
// IPv4 longest-prefix-match route table, TABLE_DEPTH slots.
// Command channel: drive func, pfx_len, addr and new_value with start high;
// the transaction is taken at a rising edge where start is high and busy is low.
// func selects lookup, insert/update or delete. Each transaction yields one
// result: done is high for exactly one cycle with status, hit, result_value,
// matched_len and entries_used valid in that cycle. The receiver cannot stall.
// After acceptance the block walks S_SCAN, then S_DONE, which registers the
// result and done. Every slot is a cell in a chain; the running best match
// moves one cell per cycle, so the chain length sets the scan time. One
// transaction is in flight at a time, so a new one is taken only once busy is
// low again; start may be held high in the cycle that done is shown.
// The table is written in the cycle after the scan completes.
// Reset clears all slot valid bits and the entry count at once; the table is
// empty and accepts a transaction in the first cycle after reset.
module ipv4_longest_prefix_match_table
    import lpm_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_BITS  = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           func,
    input  logic [LEN_BITS-1:0]                  pfx_len,
    input  logic [KEY_BITS-1:0]                  addr,
    input  logic [31:0]                          new_value,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic                                 hit,
    output logic [31:0]                          result_value,
    output logic [LEN_BITS-1:0]                  matched_len,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     entries_used
);

    localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
    localparam int SCAN_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

    state_t                state_reg;
    logic [SCAN_BITS-1:0]  scan_cnt_reg;
    lpm_op_t               op_reg;
    logic [VALUE_BITS-1:0] wr_value_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;

    logic                  done_reg;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic [31:0]           result_reg;
    logic [31:0]           result_next;
    logic [LEN_BITS-1:0]   mlen_reg;
    logic [LEN_BITS-1:0]   mlen_next;

    lpm_carry_t            carry   [TABLE_DEPTH+1];
    logic [VALUE_BITS-1:0] value_c [TABLE_DEPTH+1];
    lpm_commit_t           commit;
    lpm_commit_t           decide;

    logic [63:0]           in_value_wide;
    logic [63:0]           out_value_wide;
    logic                  bad_len;
    logic                  table_full;
    logic                  accept;

    assign accept        = start && (state_reg == S_IDLE);
    assign in_value_wide = 64'(new_value);
    assign carry[0]      = '0;
    assign value_c[0]    = '0;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            lpm_cell #(.VALUE_BITS(VALUE_BITS)) u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (op_reg),
                .wr_value  (wr_value_reg),
                .commit    (commit),
                .carry_in  (carry[gi]),
                .value_in  (value_c[gi]),
                .carry_out (carry[gi+1]),
                .value_out (value_c[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        out_value_wide = 64'(value_c[TABLE_DEPTH]);
        bad_len        = (op_reg.len == '0) || (op_reg.len > MAX_LEN);
        table_full     = (count_reg >= CNT_BITS'(TABLE_DEPTH));
        decide         = '0;
        status_next    = ST_OK;
        hit_next       = 1'b0;
        result_next    = '0;
        mlen_next      = '0;

        unique case (op_reg.func)
            FUNC_LOOKUP:
            begin
                if (carry[TABLE_DEPTH].best_len != '0)
                begin
                    hit_next    = 1'b1;
                    result_next = out_value_wide[31:0];
                    mlen_next   = carry[TABLE_DEPTH].best_len;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            FUNC_INSERT:
            begin
                if (bad_len)
                    status_next = ST_BAD_LEN;
                else if (carry[TABLE_DEPTH].exact_found)
                    decide.upd = 1'b1;
                else if (table_full)
                    status_next = ST_FULL;
                else
                    decide.ins = 1'b1;
            end
            FUNC_DELETE:
            begin
                if (bad_len)
                    status_next = ST_BAD_LEN;
                else if (carry[TABLE_DEPTH].exact_found)
                    decide.del = 1'b1;
                else
                    status_next = ST_NOT_FOUND;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        commit = (state_reg == S_DONE) ? decide : '0;

        count_next = count_reg;
        if (commit.ins)
            count_next = count_reg + CNT_BITS'(1);
        else if (commit.del && (count_reg != '0))
            count_next = count_reg - CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            status_reg   <= ST_OK;
            hit_reg      <= 1'b0;
            result_reg   <= '0;
            mlen_reg     <= '0;
        end
        else
        begin
            done_reg <= (state_reg == S_DONE);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        scan_cnt_reg <= '0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // the last cell holds the final carry once the scan has stepped through every cell
                    if (scan_cnt_reg == SCAN_BITS'(TABLE_DEPTH - 1))
                        state_reg <= S_DONE;
                    else
                        scan_cnt_reg <= scan_cnt_reg + SCAN_BITS'(1);
                end
                S_DONE:
                begin
                    count_reg  <= count_next;
                    status_reg <= status_next;
                    hit_reg    <= hit_next;
                    result_reg <= result_next;
                    mlen_reg   <= mlen_next;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg.func  <= func;
            op_reg.len   <= pfx_len;
            op_reg.addr  <= addr;
            op_reg.key   <= addr & len_mask(pfx_len);
            wr_value_reg <= in_value_wide[VALUE_BITS-1:0];
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign hit          = hit_reg;
    assign result_value = result_reg;
    assign matched_len  = mlen_reg;
    assign entries_used = count_reg;

endmodule

FILE: rtl/lpm_cell.sv
`timescale 1ns / 1ps

module lpm_cell
    import lpm_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lpm_op_t               op,
    input  logic [VALUE_BITS-1:0] wr_value,
    input  lpm_commit_t           commit,
    input  lpm_carry_t            carry_in,
    input  logic [VALUE_BITS-1:0] value_in,
    output lpm_carry_t            carry_out,
    output logic [VALUE_BITS-1:0] value_out
);

    logic                  valid_reg;
    logic [LEN_BITS-1:0]   prefix_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    lpm_carry_t            carry_reg;
    lpm_carry_t            carry_next;
    logic [VALUE_BITS-1:0] best_value_reg;
    logic [VALUE_BITS-1:0] best_value_next;

    logic match;
    logic better;
    logic exact;
    logic first_free;

    always_comb
    begin
        match      = valid_reg && (key_reg == (op.addr & len_mask(prefix_reg)));
        // strict compare keeps the lowest slot on equal lengths
        better     = match && (prefix_reg > carry_in.best_len);
        exact      = valid_reg && (prefix_reg == op.len) && (key_reg == op.key);
        first_free = !valid_reg && !carry_in.free_found;

        carry_next.best_len    = better ? prefix_reg : carry_in.best_len;
        carry_next.exact_found = carry_in.exact_found | exact;
        carry_next.free_found  = carry_in.free_found | !valid_reg;
        best_value_next        = better ? value_reg : value_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
            if (commit.ins && first_free)
                valid_reg <= 1'b1;
            else if (commit.del && exact)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        best_value_reg <= best_value_next;
        if (commit.ins && first_free)
        begin
            prefix_reg <= op.len;
            key_reg    <= op.key;
            value_reg  <= wr_value;
        end
        else if (commit.upd && exact)
        begin
            value_reg <= wr_value;
        end
    end

    assign carry_out = carry_reg;
    assign value_out = best_value_reg;

endmodule

FILE: rtl/lpm_checker.sv
`timescale 1ns / 1ps

module lpm_checker
    import lpm_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int CNT_BITS    = 7
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [1:0]          status,
    input logic                hit,
    input logic [31:0]         result_value,
    input logic [LEN_BITS-1:0] matched_len,
    input logic [CNT_BITS-1:0] entries_used
);

    // the edge that accepts a transaction raises busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe without a transaction in flight");

    a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (status == ST_OK && matched_len != '0
                           && matched_len <= MAX_LEN))
        else $error("hit with bad status or length");

    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (matched_len == '0 && result_value == '0))
        else $error("miss with nonzero match fields");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (entries_used <= CNT_BITS'(TABLE_DEPTH)))
        else $error("entry count above table depth");

endmodule

bind ipv4_longest_prefix_match_table lpm_checker
#(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CNT_BITS    (CNT_BITS)
)
u_lpm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .hit          (hit),
    .result_value (result_value),
    .matched_len  (matched_len),
    .entries_used (entries_used)
);
